[src/sbbq_pkg.sv]
// ----------------------------------------------------------------------------
// sbbq_pkg
// Shared types and codes for the buffered spi byte queues: command codes,
// controller states and the control/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package sbbq_pkg;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_XFER = 2'd0,  // transfer complete, byte is the received byte
    CMD_PUT  = 2'd1,  // put a byte to send
    CMD_GET  = 2'd2   // get a received byte
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;  // capture the incoming request
    logic read;   // registered read of both queue heads
    logic exec;   // update queues and load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;  // output register holds a result that is not taken
  } dp_stat_t;

endpackage

[src/sbbq_ctrl.sv]
// ----------------------------------------------------------------------------
// sbbq_ctrl
// Request sequencer: accepts one request, steps it through the queue head
// read and the update, and waits while the output register is still full.
// ----------------------------------------------------------------------------
module sbbq_ctrl
  import sbbq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/sbbq_dp.sv]
// ----------------------------------------------------------------------------
// sbbq_dp
// Queue datapath: transmit and receive ring buffers with pointers and fill
// counts, the idle flag of the transmitter and the output register.
// ----------------------------------------------------------------------------
module sbbq_dp
  import sbbq_pkg::*;
#(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_stat_t   stat_o,
  input  logic [1:0] cmd_code_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_load_o,
  output logic [7:0] tx_byte_o,
  output logic       ok_o,
  output logic [7:0] rx_byte_o
);

  localparam int TxPw = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RxPw = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TxCw = $clog2(TX_DEPTH + 1);
  localparam int RxCw = $clog2(RX_DEPTH + 1);

  // storage
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  // request registers
  logic [1:0] code_q;
  logic [7:0] byte_q;
  logic [7:0] tx_rdata_q, rx_rdata_q;

  // queue state
  logic [TxPw-1:0] tx_rd_ptr_q, tx_rd_ptr_d, tx_wr_ptr_q, tx_wr_ptr_d;
  logic [RxPw-1:0] rx_rd_ptr_q, rx_rd_ptr_d, rx_wr_ptr_q, rx_wr_ptr_d;
  logic [TxCw-1:0] tx_cnt_q, tx_cnt_d;
  logic [RxCw-1:0] rx_cnt_q, rx_cnt_d;
  logic            tx_idle_q, tx_idle_d;
  logic            tx_we, rx_we;

  // result
  logic       out_valid_q, out_valid_d;
  logic       load_d, ok_d;
  logic [7:0] txb_d, rxb_d;
  logic       load_q, ok_q;
  logic [7:0] txb_q, rxb_q;

  logic tx_empty, tx_full, rx_empty, rx_full;

  assign tx_empty = (tx_cnt_q == '0);
  assign tx_full  = (tx_cnt_q == TxCw'(TX_DEPTH));
  assign rx_empty = (rx_cnt_q == '0);
  assign rx_full  = (rx_cnt_q == RxCw'(RX_DEPTH));

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      code_q <= cmd_code_i;
      byte_q <= byte_in_i;
    end
  end

  // queue memories, registered head read
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      tx_rdata_q <= tx_mem[tx_rd_ptr_q];
      rx_rdata_q <= rx_mem[rx_rd_ptr_q];
    end
    if (tx_we) begin
      tx_mem[tx_wr_ptr_q] <= byte_q;
    end
    if (rx_we) begin
      rx_mem[rx_wr_ptr_q] <= byte_q;
    end
  end

  // queue update and result
  always_comb begin
    tx_rd_ptr_d = tx_rd_ptr_q;
    tx_wr_ptr_d = tx_wr_ptr_q;
    rx_rd_ptr_d = rx_rd_ptr_q;
    rx_wr_ptr_d = rx_wr_ptr_q;
    tx_cnt_d    = tx_cnt_q;
    rx_cnt_d    = rx_cnt_q;
    tx_idle_d   = tx_idle_q;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    load_d      = 1'b0;
    ok_d        = 1'b0;
    txb_d       = '0;
    rxb_d       = '0;
    if (cmd_i.exec) begin
      case (code_q)
        CMD_XFER: begin
          // next byte to the shifter, or go idle
          if (!tx_empty) begin
            load_d      = 1'b1;
            txb_d       = tx_rdata_q;
            tx_rd_ptr_d = (tx_rd_ptr_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_rd_ptr_q + 1'b1;
            tx_cnt_d    = tx_cnt_q - 1'b1;
          end else begin
            tx_idle_d = 1'b1;
          end
          // keep the received byte unless full
          if (!rx_full) begin
            rx_we       = 1'b1;
            rx_wr_ptr_d = (rx_wr_ptr_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_wr_ptr_q + 1'b1;
            rx_cnt_d    = rx_cnt_q + 1'b1;
          end
        end
        CMD_PUT: begin
          if (!tx_full) begin
            ok_d = 1'b1;
            if (tx_idle_q) begin
              load_d    = 1'b1;
              txb_d     = byte_q;
              tx_idle_d = 1'b0;
            end else begin
              tx_we       = 1'b1;
              tx_wr_ptr_d = (tx_wr_ptr_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_wr_ptr_q + 1'b1;
              tx_cnt_d    = tx_cnt_q + 1'b1;
            end
          end
        end
        CMD_GET: begin
          if (!rx_empty) begin
            ok_d        = 1'b1;
            rxb_d       = rx_rdata_q;
            rx_rd_ptr_d = (rx_rd_ptr_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_rd_ptr_q + 1'b1;
            rx_cnt_d    = rx_cnt_q - 1'b1;
          end
        end
        default: begin
          // unused code leaves everything as is
        end
      endcase
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_rd_ptr_q <= '0;
      tx_wr_ptr_q <= '0;
      rx_rd_ptr_q <= '0;
      rx_wr_ptr_q <= '0;
      tx_cnt_q    <= '0;
      rx_cnt_q    <= '0;
      tx_idle_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      tx_rd_ptr_q <= tx_rd_ptr_d;
      tx_wr_ptr_q <= tx_wr_ptr_d;
      rx_rd_ptr_q <= rx_rd_ptr_d;
      rx_wr_ptr_q <= rx_wr_ptr_d;
      tx_cnt_q    <= tx_cnt_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_idle_q   <= tx_idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      load_q <= load_d;
      txb_q  <= txb_d;
      ok_q   <= ok_d;
      rxb_q  <= rxb_d;
    end
  end

  assign stat_o.out_stall = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign tx_load_o        = load_q;
  assign tx_byte_o        = txb_q;
  assign ok_o             = ok_q;
  assign rx_byte_o        = rxb_q;

endmodule

[src/spi_buffered_byte_queues.sv]
// ----------------------------------------------------------------------------
// spi_buffered_byte_queues
// Transmit and receive byte queues in front of an spi shift register, driven
// by transfer complete, put and get requests, one result per request.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                        tuser
//  s_axis   in   [7:0] byte_in                [1:0] cmd
//  m_axis   out  [7:0] tx_byte, [15:8] rx_byte [0] tx_load, [1] ok
//
//  a result goes through a registered read of both queue heads, then the
//  queue update that loads the output register; the sequencer takes the next
//  request only after that update is done.
//  a new request is accepted while an earlier result still waits on m_axis;
//  its update stalls until that result is taken, holding off the input.
//  rst_ni clears pointers, fill counts and output valid and sets the idle flag; no clearing pass.
//
module spi_buffered_byte_queues
  import sbbq_pkg::*;
#(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] rx_byte
  output logic [1:0]  m_axis_tuser    // [0] tx_load, [1] ok
);

  ctrl_cmd_t  ctrl_cmd;
  dp_stat_t   dp_stat;
  logic       tx_load, ok;
  logic [7:0] tx_byte, rx_byte;

  // sequencer
  sbbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // queues and output register
  sbbq_dp #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .cmd_code_i  (s_axis_tuser),
    .byte_in_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .tx_load_o   (tx_load),
    .tx_byte_o   (tx_byte),
    .ok_o        (ok),
    .rx_byte_o   (rx_byte)
  );

  assign m_axis_tdata = {rx_byte, tx_byte};
  assign m_axis_tuser = {ok, tx_load};

endmodule

[src/sbbq_chk.sv]
// ----------------------------------------------------------------------------
// sbbq_chk
// Port-level checks of the buffered spi byte queues, bound to the top level.
// ----------------------------------------------------------------------------
module sbbq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // one request at a time: ready drops right after an acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  // a shifter load never comes with a popped byte
  a_load_no_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'd0)
    else $error("shifter load reported together with a received byte");

  // no load means no transmit byte
  a_txb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("transmit byte without a shifter load");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind spi_buffered_byte_queues sbbq_chk u_sbbq_chk (.*);

[dv/spi_buffered_byte_queues_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_buffered_byte_queues_checker
// Watches both stream channels of the byte queue block. Every accepted
// request runs through a local model of the transmit and receive rings.
// Every accepted result is checked field by field against the oldest
// predicted response.
// ----------------------------------------------------------------------------
module spi_buffered_byte_queues_checker
  import sbbq_pkg::*;
#(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] rx_byte
  input  logic [1:0]  m_axis_tuser,   // [0] tx_load, [1] ok
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       ok;
    logic [7:0] rx_byte;
  } spi_response_t;

  // model copy of both rings and the transmitter flag
  logic [7:0] tx_ring [TX_DEPTH];
  logic [7:0] rx_ring [RX_DEPTH];
  int         tx_rd, tx_wr, tx_fill;
  int         rx_rd, rx_wr, rx_fill;
  logic       tx_idle;

  spi_response_t pending_responses [$];
  int            fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_responses.size();

  function automatic int next_slot(int ptr, int depth);
    return (ptr == depth - 1) ? 0 : ptr + 1;
  endfunction

  // response of one request, advancing the model rings
  function automatic spi_response_t predict_response(logic [1:0] cmd, logic [7:0] data);
    spi_response_t r;
    r = '0;
    case (cmd)
      CMD_XFER: begin
        // next queued byte goes to the shift register, else go idle
        if (tx_fill > 0) begin
          r.tx_load = 1'b1;
          r.tx_byte = tx_ring[tx_rd];
          tx_rd     = next_slot(tx_rd, TX_DEPTH);
          tx_fill   = tx_fill - 1;
        end else begin
          tx_idle = 1'b1;
        end
        // received byte is dropped when the receive ring is full
        if (rx_fill < RX_DEPTH) begin
          rx_ring[rx_wr] = data;
          rx_wr          = next_slot(rx_wr, RX_DEPTH);
          rx_fill        = rx_fill + 1;
        end
      end
      CMD_PUT: begin
        // full ring refuses even with the transmitter idle
        if (tx_fill < TX_DEPTH) begin
          if (tx_idle) begin
            r.tx_load = 1'b1;
            r.tx_byte = data;
            tx_idle   = 1'b0;
          end else begin
            tx_ring[tx_wr] = data;
            tx_wr          = next_slot(tx_wr, TX_DEPTH);
            tx_fill        = tx_fill + 1;
          end
          r.ok = 1'b1;
        end
      end
      CMD_GET: begin
        if (rx_fill > 0) begin
          r.rx_byte = rx_ring[rx_rd];
          rx_rd     = next_slot(rx_rd, RX_DEPTH);
          rx_fill   = rx_fill - 1;
          r.ok      = 1'b1;
        end
      end
      default: begin
        // unused code leaves everything as it is
      end
    endcase
    return r;
  endfunction

  // compare results first, then predict the request of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    spi_response_t want, got;
    if (!rst_ni) begin
      tx_rd      = 0;
      tx_wr      = 0;
      tx_fill    = 0;
      rx_rd      = 0;
      rx_wr      = 0;
      rx_fill    = 0;
      tx_idle    = 1'b1;
      fail_count = 0;
      pending_responses.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.tx_load = m_axis_tuser[0];
        got.ok      = m_axis_tuser[1];
        got.tx_byte = m_axis_tdata[7:0];
        got.rx_byte = m_axis_tdata[15:8];
        if (pending_responses.size() == 0) begin
          $display("%0t: result with no request waiting, actual %h", $time, got);
          fail_count = fail_count + 1;
        end else begin
          want = pending_responses.pop_front();
          if (got.tx_load !== want.tx_load) begin
            $display("%0t: tx_load expected %0b actual %0b", $time, want.tx_load,
                     got.tx_load);
            fail_count = fail_count + 1;
          end
          if (got.tx_byte !== want.tx_byte) begin
            $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte,
                     got.tx_byte);
            fail_count = fail_count + 1;
          end
          if (got.ok !== want.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
            fail_count = fail_count + 1;
          end
          if (got.rx_byte !== want.rx_byte) begin
            $display("%0t: rx_byte expected %h actual %h", $time, want.rx_byte,
                     got.rx_byte);
            fail_count = fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_responses.push_back(predict_response(s_axis_tuser, s_axis_tdata));
      end
    end
  end

endmodule

[dv/spi_buffered_byte_queues_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_buffered_byte_queues_tb
// Drives transfer complete, put and get requests into the byte queue block
// with random gaps and receiver stalls: a short directed opening, then
// bursts that fill and drain both rings, plus one long receiver hold-off.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module spi_buffered_byte_queues_tb;
  import sbbq_pkg::*;

  // unused command code, not part of the package enum
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int REQUEST_TARGET = 1700;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_in
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] tx_byte, [15:8] rx_byte
  logic [1:0]  m_axis_tuser;   // [0] tx_load, [1] ok

  int   fail_count;
  int   pending;
  int   requests_sent;
  int   hold_requests;
  int   hold_served;
  logic burst_no_gap;

  spi_buffered_byte_queues dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spi_buffered_byte_queues_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // idle length, mostly short with a few long ones
  function automatic int pick_gap(logic no_gap);
    int r;
    r = $urandom_range(0, 99);
    if (no_gap || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(logic [1:0] cmd, logic [7:0] data);
    int gap;
    gap = pick_gap(burst_no_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent = requests_sent + 1;
  endtask

  // receiver with random stalls and one long hold-off on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    hold_served = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_served < hold_requests) begin
        hold_served = hold_served + 1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = pick_gap($urandom_range(0, 4) == 0);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // stimulus and verdict
  initial begin
    int kind, len;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_XFER;
    requests_sent = 0;
    hold_requests = 0;
    burst_no_gap  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty rings, direct load, queued bytes, unused code
    send_request(CMD_GET, 8'h00);
    send_request(CMD_XFER, 8'h00);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_PUT, 8'hFF);
    send_request(CMD_PUT, 8'h00);
    send_request(CMD_PUT, 8'hA5);
    send_request(CMD_UNUSED, 8'hFF);
    send_request(CMD_XFER, 8'hFF);
    send_request(CMD_XFER, 8'h5A);
    send_request(CMD_XFER, 8'h01);
    send_request(CMD_PUT, 8'h80);
    send_request(CMD_UNUSED, 8'h00);
    send_request(CMD_GET, 8'hFF);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_XFER, 8'h7F);
    send_request(CMD_GET, 8'h00);

    // random bursts that fill and drain both rings
    while (requests_sent < REQUEST_TARGET) begin
      // one long receiver hold-off while puts keep coming
      if (hold_requests == 0 && requests_sent > 600) begin
        hold_requests = 1;
        burst_no_gap  = 1'b1;
        repeat (40) send_request(CMD_PUT, 8'($urandom_range(0, 255)));
      end
      burst_no_gap = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 20);
      repeat (len) begin
        case (kind)
          0, 1, 2: send_request(CMD_PUT, 8'($urandom_range(0, 255)));
          3, 4, 5: send_request(CMD_XFER, 8'($urandom_range(0, 255)));
          6, 7:    send_request(CMD_GET, 8'($urandom_range(0, 255)));
          default: send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        endcase
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain and settle
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("spi_buffered_byte_queues: match");
    end else begin
      $display("spi_buffered_byte_queues: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #15_000_000;
    $display("spi_buffered_byte_queues: mismatch");
    $finish;
  end

endmodule
